### src/tac_pkg.sv
// Package for the timed associative cache: sizes, entry layout, request codes
// and the controller state type. No dependencies.
package tac_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int DATA_W  = 64;

  localparam logic REQ_LOOKUP = 1'b0;
  localparam logic REQ_INSERT = 1'b1;

  typedef struct packed {
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] value;
    logic [DATA_W-1:0] stamp;
  } tac_entry_t;

  localparam int ENTRY_W = $bits(tac_entry_t);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } tac_state_t;

endpackage

### src/tac_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module tac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### src/timed_associative_cache_top.sv
// Timed associative cache, top level. Uses tac_pkg and one tac_ram for the entries.
// Insert: the entry is written on acceptance; the result is posted from ST_DONE.
// Lookup: one entry read per cycle through the RAM read port, stopping at the first valid,
//   unexpired match or after ENTRIES entries. A new transaction is taken only in ST_IDLE.
// Reset clears valid bits, fill pointer and control state; entry RAM needs no clearing.
module timed_associative_cache_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_req_type,
  input  logic [tac_pkg::DATA_W-1:0] in_lookup_key,
  input  logic [tac_pkg::DATA_W-1:0] in_insert_value,
  input  logic [tac_pkg::DATA_W-1:0] in_current_time,
  input  logic [tac_pkg::DATA_W-1:0] in_max_age,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_hit,
  output logic [tac_pkg::DATA_W-1:0] out_found_value
);
  import tac_pkg::*;

  tac_state_t         state_r, state_nxt;
  logic [IDX_W-1:0]   scan_idx_r, scan_idx_nxt;
  logic [IDX_W-1:0]   fill_ptr_r, fill_ptr_nxt;
  logic [ENTRIES-1:0] entry_valid_r, entry_valid_nxt;
  logic [DATA_W-1:0]  key_r, key_nxt;
  logic [DATA_W-1:0]  now_r, now_nxt;
  logic [DATA_W-1:0]  age_limit_r, age_limit_nxt;
  logic               res_hit_r, res_hit_nxt;
  logic [DATA_W-1:0]  res_value_r, res_value_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_hit_r, out_hit_nxt;
  logic [DATA_W-1:0]  out_value_r, out_value_nxt;

  logic               accept;
  logic               out_free;
  logic               ram_we;
  logic [IDX_W-1:0]   ram_raddr;
  tac_entry_t         ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  tac_entry_t         rd_entry;
  logic [DATA_W-1:0]  age;
  logic               match;
  logic               last;

  tac_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (fill_ptr_r),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign rd_entry = tac_entry_t'(ram_rdata);
  assign age      = now_r - rd_entry.stamp;
  assign last     = (scan_idx_r == IDX_W'(ENTRIES - 1));
  assign match    = entry_valid_r[scan_idx_r] && (rd_entry.key == key_r) &&
                    (age < age_limit_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_req_type == REQ_INSERT) ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (match || last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready        = (state_r == ST_IDLE);
    ram_we          = accept && (in_req_type == REQ_INSERT);
    ram_wdata.key   = in_lookup_key;
    ram_wdata.value = in_insert_value;
    ram_wdata.stamp = in_current_time;
    if (state_r == ST_SCAN && !last) begin
      ram_raddr = scan_idx_r + IDX_W'(1);
    end else begin
      ram_raddr = '0;
    end
  end

  always_comb begin
    scan_idx_nxt    = scan_idx_r;
    fill_ptr_nxt    = fill_ptr_r;
    entry_valid_nxt = entry_valid_r;
    key_nxt         = key_r;
    now_nxt         = now_r;
    age_limit_nxt   = age_limit_r;
    res_hit_nxt     = res_hit_r;
    res_value_nxt   = res_value_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_hit_nxt     = out_hit_r;
    out_value_nxt   = out_value_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          scan_idx_nxt  = '0;
          key_nxt       = in_lookup_key;
          now_nxt       = in_current_time;
          age_limit_nxt = in_max_age;
          res_hit_nxt   = 1'b0;
          res_value_nxt = '0;
          if (in_req_type == REQ_INSERT) begin
            entry_valid_nxt[fill_ptr_r] = 1'b1;
            fill_ptr_nxt = (fill_ptr_r == IDX_W'(ENTRIES - 1)) ? '0 :
                           fill_ptr_r + IDX_W'(1);
          end
        end
      end
      ST_SCAN: begin
        if (match) begin
          res_hit_nxt   = 1'b1;
          res_value_nxt = rd_entry.value;
        end else if (!last) begin
          scan_idx_nxt = scan_idx_r + IDX_W'(1);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_hit_nxt   = res_hit_r;
          out_value_nxt = res_value_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      fill_ptr_r    <= '0;
      entry_valid_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      fill_ptr_r    <= fill_ptr_nxt;
      entry_valid_r <= entry_valid_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_idx_r  <= scan_idx_nxt;
    key_r       <= key_nxt;
    now_r       <= now_nxt;
    age_limit_r <= age_limit_nxt;
    res_hit_r   <= res_hit_nxt;
    res_value_r <= res_value_nxt;
    out_hit_r   <= out_hit_nxt;
    out_value_r <= out_value_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_found_value = out_value_r;

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_SCAN || state_r == ST_DONE))
    else $error("transaction accepted but controller stayed idle");

  a_insert_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_req_type == REQ_INSERT) |=> entry_valid_r[$past(fill_ptr_r)])
    else $error("insert did not set the entry valid bit");

  a_hit_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && match) |-> entry_valid_r[scan_idx_r])
    else $error("hit on an invalid entry");

  a_miss_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_hit_r) |-> (out_value_r == '0))
    else $error("miss result carries a non-zero value");

  a_result_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && out_free) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("finished transaction not moved to the result register");

endmodule

### tb/timed_associative_cache_top_tb.sv
// Self-checking testbench for timed_associative_cache_top: directed and random lookups and
// inserts, checked against a cycle-free shadow of the cache. Depends on tac_pkg and the RTL.
module timed_associative_cache_top_tb;
  import tac_pkg::*;

  typedef struct packed {
    logic              hit;
    logic [DATA_W-1:0] value;
  } cache_answer_t;

  localparam logic [DATA_W-1:0] ALL_ONES = {DATA_W{1'b1}};

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              in_req_type = REQ_LOOKUP;
  logic [DATA_W-1:0] in_lookup_key = '0;
  logic [DATA_W-1:0] in_insert_value = '0;
  logic [DATA_W-1:0] in_current_time = '0;
  logic [DATA_W-1:0] in_max_age = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              out_hit;
  logic [DATA_W-1:0] out_found_value;

  tac_entry_t        shadow_entry [ENTRIES];
  bit                shadow_live  [ENTRIES];
  int unsigned       shadow_fill;
  cache_answer_t     expected_answers [$];

  bit                idle_on = 1'b1;
  int                err_count = 0;
  int                n_lookups = 0;
  int                n_hits = 0;
  int                n_zero_age = 0;
  int                n_inserts = 0;
  int                n_wraps = 0;
  logic [DATA_W-1:0] key_pool [6];
  logic [DATA_W-1:0] tick_now;

  timed_associative_cache_top u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_lookup_key   (in_lookup_key),
    .in_insert_value (in_insert_value),
    .in_current_time (in_current_time),
    .in_max_age      (in_max_age),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_hit         (out_hit),
    .out_found_value (out_found_value)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("*** FAILED ***");
    $finish;
  end

  always @(posedge clk) begin
    out_ready <= idle_on ? ($urandom_range(0, 99) >= 36) : 1'b1;
  end

  // Shadow the cache on every accepted transaction.
  always @(posedge clk) begin : predict_answer
    cache_answer_t     answer;
    logic [DATA_W-1:0] age;
    if (!rst_n) begin
      shadow_fill = 0;
      for (int i = 0; i < ENTRIES; i++) shadow_live[i] = 1'b0;
    end else if (in_valid && in_ready) begin
      answer = '0;
      if (in_req_type == REQ_INSERT) begin
        shadow_entry[shadow_fill] = '{key: in_lookup_key, value: in_insert_value,
                                      stamp: in_current_time};
        shadow_live[shadow_fill] = 1'b1;
        if (shadow_fill == ENTRIES - 1) begin
          shadow_fill = 0;
          n_wraps++;
        end else begin
          shadow_fill++;
        end
        n_inserts++;
      end else begin
        n_lookups++;
        if (in_max_age == '0) n_zero_age++;
        for (int i = 0; i < ENTRIES; i++) begin
          age = in_current_time - shadow_entry[i].stamp;
          if (!answer.hit && shadow_live[i] && shadow_entry[i].key == in_lookup_key &&
              age < in_max_age) begin
            answer.hit   = 1'b1;
            answer.value = shadow_entry[i].value;
          end
        end
        if (answer.hit) n_hits++;
      end
      expected_answers.push_back(answer);
    end
  end

  always @(posedge clk) begin : check_answer
    cache_answer_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_answers.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual hit=%0b found_value=%h",
                 $time, out_hit, out_found_value);
        err_count++;
      end else begin
        want = expected_answers.pop_front();
        if (out_hit !== want.hit) begin
          $display("%0t: hit mismatch, expected %0b, actual %0b", $time, want.hit, out_hit);
          err_count++;
        end
        if (out_found_value !== want.value) begin
          $display("%0t: found_value mismatch, expected %h, actual %h", $time, want.value,
                   out_found_value);
          err_count++;
        end
      end
    end
  end

  function automatic logic [DATA_W-1:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic send_txn(input logic req, input logic [DATA_W-1:0] key,
                          input logic [DATA_W-1:0] val, input logic [DATA_W-1:0] now,
                          input logic [DATA_W-1:0] age);
    while (idle_on && $urandom_range(0, 99) < 36) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_req_type     <= req;
    in_lookup_key   <= key;
    in_insert_value <= val;
    in_current_time <= now;
    in_max_age      <= age;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_answers.size() != 0) @(posedge clk);
  endtask

  task automatic test_cold_miss();
    send_txn(REQ_LOOKUP, '0, ALL_ONES, '0, ALL_ONES);
    send_txn(REQ_LOOKUP, ALL_ONES, '0, ALL_ONES, ALL_ONES);
  endtask

  task automatic test_timeout_edges();
    send_txn(REQ_INSERT, '0, ALL_ONES, '0, '0);
    send_txn(REQ_LOOKUP, '0, '0, 64'd5, 64'd6);
    send_txn(REQ_LOOKUP, '0, '0, 64'd5, 64'd5);
    send_txn(REQ_LOOKUP, '0, ALL_ONES, '0, '0);
    send_txn(REQ_LOOKUP, '0, '0, 64'd5, ALL_ONES);
  endtask

  task automatic test_time_wrap();
    send_txn(REQ_INSERT, ALL_ONES, '0, ALL_ONES, ALL_ONES);
    send_txn(REQ_LOOKUP, ALL_ONES, '0, '0, 64'd2);
    send_txn(REQ_LOOKUP, ALL_ONES, '0, '0, 64'd1);
    send_txn(REQ_INSERT, 64'h1234_5678_9abc_def0, 64'h55, 64'd1000, '0);
    send_txn(REQ_LOOKUP, 64'h1234_5678_9abc_def0, '0, 64'd500, 64'h100_0000_0000);
    send_txn(REQ_LOOKUP, 64'h1234_5678_9abc_def0, '0, 64'd500, ALL_ONES);
  endtask

  task automatic test_duplicate_keys();
    send_txn(REQ_INSERT, 64'hdead_beef, 64'haaaa, 64'd2000, '0);
    send_txn(REQ_INSERT, 64'hdead_beef, 64'hbbbb, 64'd2000, '0);
    send_txn(REQ_LOOKUP, 64'hdead_beef, '0, 64'd2001, 64'd10);
    drain_results();
  endtask

  task automatic test_random_traffic(input int count);
    logic              req;
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] now;
    logic [DATA_W-1:0] age;
    int                pick;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < 3) key_pool[$urandom_range(0, 5)] = rand64();
      if ($urandom_range(0, 99) < 2) tick_now = rand64();
      tick_now += DATA_W'($urandom_range(0, 40));
      req = ($urandom_range(0, 99) < 30) ? REQ_INSERT : REQ_LOOKUP;
      key = ($urandom_range(0, 99) < 88) ? key_pool[$urandom_range(0, 5)] : rand64();
      now = ($urandom_range(0, 99) < 92) ? tick_now : rand64();
      pick = $urandom_range(0, 99);
      if (pick < 10)      age = '0;
      else if (pick < 55) age = DATA_W'($urandom_range(1, 300));
      else if (pick < 70) age = DATA_W'($urandom_range(1, 60));
      else if (pick < 85) age = ALL_ONES;
      else                age = rand64();
      send_txn(req, key, rand64(), now, age);
    end
  endtask

  initial begin
    foreach (key_pool[i]) key_pool[i] = rand64();
    key_pool[0] = '0;
    key_pool[1] = ALL_ONES;
    tick_now = rand64();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_cold_miss();
    test_timeout_edges();
    test_time_wrap();
    test_duplicate_keys();
    test_random_traffic(520);
    drain_results();
    idle_on = 1'b0;
    test_random_traffic(300);
    idle_on = 1'b1;
    test_random_traffic(520);
    drain_results();
    repeat (ENTRIES + 8) @(posedge clk);
    $display("Ran %0d lookups (%0d hits, %0d with zero timeout) and %0d inserts;",
             n_lookups, n_hits, n_zero_age, n_inserts);
    $display("fill pointer wrapped %0d times, with and without back-pressure.", n_wraps);
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
